[rtl/tca_pkg.sv]
// Shared widths, limits and the slot record of the top-k contributor accumulator.
package tca_pkg;

  localparam int ID_W          = 31;
  localparam int SIG_W         = 32;
  localparam int ENT_W         = 40;
  localparam int TOT_W         = 48;
  localparam int RANK_W        = 3;
  localparam int COUNT_W       = 4;
  localparam int DEF_LIST_DEPTH = 8;

  // Kind codes of an input item.
  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  // Clamp value for the incoming signal (the most negative code maps to one above it, -2147483647).
  localparam logic signed [SIG_W-1:0] SIG_NEG_LIM = -32'sd2147483647;
  localparam logic signed [SIG_W-1:0] SIG_MOST_NEG = 32'sh8000_0000;

  // Saturation limits, held at the adder's internal width.
  localparam logic signed [TOT_W:0] ENT_HI = 49'sd549755813887;
  localparam logic signed [TOT_W:0] ENT_LO = -49'sd549755813888;
  localparam logic signed [TOT_W:0] TOT_HI = 49'sd140737488355327;
  localparam logic signed [TOT_W:0] TOT_LO = -49'sd140737488355328;

  typedef struct packed {
    logic [ID_W-1:0]         track;
    logic [ID_W-1:0]         hit;
    logic signed [ENT_W-1:0] sig;
  } slot_t;

endpackage

[rtl/tca_sat_add.sv]
// Shared saturating adder for the running total and the per-track accumulation.
module tca_sat_add (
  input  logic signed [tca_pkg::TOT_W-1:0] acc,
  input  logic signed [tca_pkg::SIG_W-1:0] addend,
  input  logic                             narrow,
  output logic signed [tca_pkg::TOT_W-1:0] sum
);
  import tca_pkg::*;

  logic signed [TOT_W:0] raw;
  logic signed [TOT_W:0] hi;
  logic signed [TOT_W:0] lo;

  assign raw = $signed({acc[TOT_W-1], acc}) +
               $signed({{(TOT_W+1-SIG_W){addend[SIG_W-1]}}, addend});
  assign hi  = narrow ? ENT_HI : TOT_HI;
  assign lo  = narrow ? ENT_LO : TOT_LO;

  always_comb begin
    if (raw > hi) begin
      sum = hi[TOT_W-1:0];
    end else if (raw < lo) begin
      sum = lo[TOT_W-1:0];
    end else begin
      sum = raw[TOT_W-1:0];
    end
  end

endmodule

[rtl/tca_slot_store.sv]
// Slot register file: one write and one read address per cycle.
module tca_slot_store #(
  parameter int LIST_DEPTH = tca_pkg::DEF_LIST_DEPTH
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(LIST_DEPTH)-1:0] wr_addr,
  input  tca_pkg::slot_t                wr_data,
  input  logic [$clog2(LIST_DEPTH)-1:0] rd_addr,
  output tca_pkg::slot_t                rd_data
);
  import tca_pkg::*;

  slot_t slots_r [LIST_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = slots_r[rd_addr];

endmodule

[rtl/topk_contributor_accumulator_core.sv]
// Top level: sequencer of the top-k contributor list with shared adder and compare.
// Clear item: no result items; in_ready stays high.
// Add item (n entries held before): accept, total, search, then update or drop-check,
// then move and place (both skipped on a drop), then one emit per held entry while out_ready is
// high; the run lasts longer while out_ready stalls.
// Reset (synchronous, rst_n low) empties the list, zeroes the total and drops out_valid.
module topk_contributor_accumulator_core #(
  parameter int LIST_DEPTH = tca_pkg::DEF_LIST_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_kind,
  input  logic [tca_pkg::ID_W-1:0]               in_track_id,
  input  logic [tca_pkg::ID_W-1:0]               in_hit_id,
  input  logic signed [tca_pkg::SIG_W-1:0]       in_signal_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [tca_pkg::RANK_W-1:0]             out_rank,
  output logic [tca_pkg::ID_W-1:0]               out_entry_track,
  output logic [tca_pkg::ID_W-1:0]               out_entry_hit,
  output logic signed [tca_pkg::ENT_W-1:0]       out_entry_signal,
  output logic signed [tca_pkg::TOT_W-1:0]       out_total_signal,
  output logic [tca_pkg::COUNT_W-1:0]            out_entry_count,
  output logic                                   out_dropped,
  output logic                                   out_last_entry
);
  import tca_pkg::*;

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIST_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SEARCH,
    ST_UPDATE,
    ST_DROPCHK,
    ST_MOVE,
    ST_PLACE,
    ST_EMIT
  } state_t;

  state_t                  state_r,   state_nxt;
  logic [IDX_W-1:0]        idx_r,     idx_nxt;
  logic [CNT_W-1:0]        cnt_r,     cnt_nxt;
  logic signed [TOT_W-1:0] total_r,   total_nxt;
  slot_t                   cur_r,     cur_nxt;
  logic signed [SIG_W-1:0] sig_r,     sig_nxt;
  logic                    up_r,      up_nxt;
  logic                    drop_r,    drop_nxt;

  logic                    ov_r,      ov_nxt;
  logic [RANK_W-1:0]       o_rank_r,  o_rank_nxt;
  slot_t                   o_slot_r,  o_slot_nxt;
  logic signed [TOT_W-1:0] o_total_r, o_total_nxt;
  logic [COUNT_W-1:0]      o_cnt_r,   o_cnt_nxt;
  logic                    o_drop_r,  o_drop_nxt;
  logic                    o_last_r,  o_last_nxt;

  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  slot_t                   wr_data;
  logic [IDX_W-1:0]        rd_addr;
  slot_t                   rd_data;

  logic signed [TOT_W-1:0] add_acc;
  logic signed [TOT_W-1:0] add_sum;
  logic                    add_narrow;

  logic signed [SIG_W-1:0] sig_clamped;
  logic                    at_top;     // idx_r is the last held entry
  logic                    out_free;

  // Clamp the most negative input code onto the symmetric range.
  assign sig_clamped = (in_signal_value == SIG_MOST_NEG) ? SIG_NEG_LIM : in_signal_value;

  assign at_top   = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
  assign out_free = !ov_r || out_ready;

  tca_slot_store #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // One adder serves the total (ACCUM) and the found entry (UPDATE).
  assign add_narrow = (state_r != ST_ACCUM);
  assign add_acc    = (state_r == ST_ACCUM) ? total_r
                    : {{(TOT_W-ENT_W){rd_data.sig[ENT_W-1]}}, rd_data.sig};

  tca_sat_add u_add (
    .acc    (add_acc),
    .addend (sig_r),
    .narrow (add_narrow),
    .sum    (add_sum)
  );

  // Read address: the last slot in drop-check, the moving entry's neighbor while shifting, the pointer otherwise.
  always_comb begin
    unique case (state_r)
      ST_DROPCHK: rd_addr = LAST_IDX;
      ST_MOVE:    rd_addr = up_r ? (idx_r - IDX_W'(1)) : (idx_r + IDX_W'(1));
      default:    rd_addr = idx_r;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    total_nxt   = total_r;
    cur_nxt     = cur_r;
    sig_nxt     = sig_r;
    up_nxt      = up_r;
    drop_nxt    = drop_r;
    ov_nxt      = ov_r && !out_ready;
    o_rank_nxt  = o_rank_r;
    o_slot_nxt  = o_slot_r;
    o_total_nxt = o_total_r;
    o_cnt_nxt   = o_cnt_r;
    o_drop_nxt  = o_drop_r;
    o_last_nxt  = o_last_r;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = cur_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_CLEAR) begin
            // Empty the list; old slots stay but are never read again.
            cnt_nxt   = '0;
            total_nxt = '0;
          end else begin
            cur_nxt.track = in_track_id;
            cur_nxt.hit   = in_hit_id;
            cur_nxt.sig   = {{(ENT_W-SIG_W){sig_clamped[SIG_W-1]}}, sig_clamped};
            sig_nxt       = sig_clamped;
            drop_nxt      = 1'b0;
            state_nxt     = ST_ACCUM;
          end
        end
      end

      ST_ACCUM: begin
        total_nxt = add_sum;
        if (cnt_r == '0) begin
          // Empty list: skip the search and place at rank zero.
          idx_nxt   = '0;
          cnt_nxt   = CNT_W'(1);
          up_nxt    = 1'b1;
          state_nxt = ST_MOVE;
        end else begin
          idx_nxt   = IDX_W'(cnt_r - CNT_W'(1));
          state_nxt = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        // Scan from the bottom of the list toward rank zero.
        if (rd_data.track == cur_r.track) begin
          state_nxt = ST_UPDATE;
        end else if (idx_r == '0) begin
          if (cnt_r == FULL_CNT) begin
            state_nxt = ST_DROPCHK;
          end else begin
            idx_nxt   = IDX_W'(cnt_r);
            cnt_nxt   = cnt_r + CNT_W'(1);
            up_nxt    = 1'b1;
            state_nxt = ST_MOVE;
          end
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end

      ST_UPDATE: begin
        cur_nxt.track = rd_data.track;
        cur_nxt.hit   = rd_data.hit;
        cur_nxt.sig   = add_sum[ENT_W-1:0];
        up_nxt        = !sig_r[SIG_W-1];
        state_nxt     = ST_MOVE;
      end

      ST_DROPCHK: begin
        // Full list: a newcomer no stronger than the weakest entry is not kept.
        if ($signed(cur_r.sig) <= $signed(rd_data.sig)) begin
          drop_nxt  = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt   = LAST_IDX;
          up_nxt    = 1'b1;
          state_nxt = ST_MOVE;
        end
      end

      ST_MOVE: begin
        // Shift one neighbor into the hole per cycle until the order holds.
        if (up_r) begin
          if (idx_r == '0) begin
            state_nxt = ST_PLACE;
          end else if ($signed(cur_r.sig) > $signed(rd_data.sig)) begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_nxt = idx_r - IDX_W'(1);
          end else begin
            state_nxt = ST_PLACE;
          end
        end else begin
          if (at_top) begin
            state_nxt = ST_PLACE;
          end else if ($signed(rd_data.sig) > $signed(cur_r.sig)) begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_nxt = idx_r + IDX_W'(1);
          end else begin
            state_nxt = ST_PLACE;
          end
        end
      end

      ST_PLACE: begin
        wr_en     = 1'b1;
        wr_data   = cur_r;
        idx_nxt   = '0;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        // Load the next result item as soon as the output register frees up.
        if (out_free) begin
          ov_nxt      = 1'b1;
          o_rank_nxt  = RANK_W'(idx_r);
          o_slot_nxt  = rd_data;
          o_total_nxt = total_r;
          o_cnt_nxt   = COUNT_W'(cnt_r);
          o_drop_nxt  = drop_r;
          o_last_nxt  = at_top;
          if (at_top) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r     <= idx_nxt;
    cur_r     <= cur_nxt;
    sig_r     <= sig_nxt;
    up_r      <= up_nxt;
    drop_r    <= drop_nxt;
    o_rank_r  <= o_rank_nxt;
    o_slot_r  <= o_slot_nxt;
    o_total_r <= o_total_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_drop_r  <= o_drop_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = ov_r;
  assign out_rank         = o_rank_r;
  assign out_entry_track  = o_slot_r.track;
  assign out_entry_hit    = o_slot_r.hit;
  assign out_entry_signal = o_slot_r.sig;
  assign out_total_signal = o_total_r;
  assign out_entry_count  = o_cnt_r;
  assign out_dropped      = o_drop_r;
  assign out_last_entry   = o_last_r;

endmodule

[rtl/tca_checker.sv]
// Port-level checks of the top-k contributor accumulator, bound to the top level.
module tca_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_kind,
  input logic [tca_pkg::ID_W-1:0]          in_track_id,
  input logic [tca_pkg::ID_W-1:0]          in_hit_id,
  input logic signed [tca_pkg::SIG_W-1:0]  in_signal_value,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tca_pkg::RANK_W-1:0]        out_rank,
  input logic [tca_pkg::ID_W-1:0]          out_entry_track,
  input logic [tca_pkg::ID_W-1:0]          out_entry_hit,
  input logic signed [tca_pkg::ENT_W-1:0]  out_entry_signal,
  input logic signed [tca_pkg::TOT_W-1:0]  out_total_signal,
  input logic [tca_pkg::COUNT_W-1:0]       out_entry_count,
  input logic                              out_dropped,
  input logic                              out_last_entry
);
  import tca_pkg::*;

  // Waiting input item holds.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_kind) && $stable(in_track_id) &&
      $stable(in_hit_id) && $stable(in_signal_value))
    else $error("waiting input item changed");

  // Stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rank) &&
      $stable(out_entry_track) && $stable(out_entry_hit) && $stable(out_entry_signal) &&
      $stable(out_total_signal) && $stable(out_entry_count) && $stable(out_dropped) &&
      $stable(out_last_entry))
    else $error("stalled result item changed");

  // Ranks of one add run back to back without gaps.
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_entry |=>
      out_valid && (out_rank == RANK_W'($past(out_rank) + RANK_W'(1))))
    else $error("rank sequence broken");

  // The final item of an add sits at rank count minus one.
  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_entry |->
      (out_rank == RANK_W'(out_entry_count - COUNT_W'(1))))
    else $error("last item at wrong rank");

  // No new item is taken while an add still has entries to emit.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_entry |-> !in_ready)
    else $error("input taken during emission");

endmodule

bind topk_contributor_accumulator_core tca_checker u_tca_checker (.*);

[test/tb.sv]
// Self-checking testbench for the top-k contributor accumulator core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tca_pkg::*;

  localparam int LIST_DEPTH   = DEF_LIST_DEPTH;
  localparam int SCRIPT_LEN   = 20;
  // Full-scale adds per run on one track: carries the sums well past 32 bits.
  localparam int SAT_ADDS     = 6;
  localparam int DRAIN_CYCLES = 30;   // quiet time after each settle
  localparam int HOLD_CYCLES  = 300;
  localparam int POOL_SIZE    = 10;

  // One emitted list entry.
  typedef struct packed {
    logic [RANK_W-1:0]       rank;
    logic [ID_W-1:0]         track;
    logic [ID_W-1:0]         hit;
    logic signed [ENT_W-1:0] sig;
    logic signed [TOT_W-1:0] total;
    logic [COUNT_W-1:0]      count;
    logic                    dropped;
    logic                    last;
  } ranked_entry_t;

  // Directed row; typed rows carry their single expected entry (rank 0, count 1, kept).
  typedef struct packed {
    kind_t                   kind;
    logic [ID_W-1:0]         trk;
    logic [ID_W-1:0]         hit;
    logic signed [SIG_W-1:0] sig;
    logic                    typed;
    logic [ID_W-1:0]         w_hit;
    logic signed [ENT_W-1:0] w_sig;
    logic signed [TOT_W-1:0] w_total;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_kind;
  logic [ID_W-1:0]         in_track_id;
  logic [ID_W-1:0]         in_hit_id;
  logic signed [SIG_W-1:0] in_signal_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [RANK_W-1:0]       out_rank;
  logic [ID_W-1:0]         out_entry_track;
  logic [ID_W-1:0]         out_entry_hit;
  logic signed [ENT_W-1:0] out_entry_signal;
  logic signed [TOT_W-1:0] out_total_signal;
  logic [COUNT_W-1:0]      out_entry_count;
  logic                    out_dropped;
  logic                    out_last_entry;

  // Predictor state: the sorted list and the running total.
  logic [ID_W-1:0] list_track [LIST_DEPTH];
  logic [ID_W-1:0] list_hit   [LIST_DEPTH];
  longint          list_sig   [LIST_DEPTH];
  int              list_count;
  longint          running_total;

  ranked_entry_t awaited_entries [$];
  stim_row_t     script [SCRIPT_LEN];
  logic [ID_W-1:0] track_pool [POOL_SIZE];

  int gap_pct, stall_pct, hold_left;
  int errors, items_accepted, clears_accepted, sat_adds_done, entries_checked, drops_seen;

  topk_contributor_accumulator_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(4_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Apply one accepted item to the predicted list and queue the entries it emits.
  function automatic void rank_contribution(kind_t kind, logic [ID_W-1:0] trk,
                                            logic [ID_W-1:0] hit,
                                            logic signed [SIG_W-1:0] raw);
    longint s, ts;
    logic [ID_W-1:0] tt, th;
    int n, j;
    bit found, drop;
    ranked_entry_t e;
    if (kind == KIND_CLEAR) begin
      // Clear empties the list and total; the slots are simply no longer read.
      list_count = 0;
      running_total = 0;
      return;
    end
    s = raw;
    if (s < longint'(SIG_NEG_LIM)) s = SIG_NEG_LIM;
    running_total = clip(running_total + s, longint'(TOT_LO), longint'(TOT_HI));
    n = list_count;
    found = 0;
    drop = 0;
    // Search from the tail; ids in the list are unique.
    for (int i = n - 1; i >= 0; i--) begin
      if (!found && list_track[i] == trk) begin
        list_sig[i] = clip(list_sig[i] + s, longint'(ENT_LO), longint'(ENT_HI));
        found = 1;
      end
    end
    if (found) begin
      // Stable insertion sort, descending.
      for (int i = 1; i < n; i++) begin
        j = i;
        while (j > 0 && list_sig[j] > list_sig[j-1]) begin
          tt = list_track[j]; list_track[j] = list_track[j-1]; list_track[j-1] = tt;
          th = list_hit[j];   list_hit[j]   = list_hit[j-1];   list_hit[j-1]   = th;
          ts = list_sig[j];   list_sig[j]   = list_sig[j-1];   list_sig[j-1]   = ts;
          j--;
        end
      end
    end else if (n == LIST_DEPTH && s <= list_sig[LIST_DEPTH-1]) begin
      drop = 1;
    end else begin
      // Evict the tail when full, then slide in after all equal or larger signals.
      if (n == LIST_DEPTH) n = LIST_DEPTH - 1;
      j = n;
      while (j > 0 && s > list_sig[j-1]) begin
        list_track[j] = list_track[j-1];
        list_hit[j]   = list_hit[j-1];
        list_sig[j]   = list_sig[j-1];
        j--;
      end
      list_track[j] = trk;
      list_hit[j]   = hit;
      list_sig[j]   = s;
      list_count    = n + 1;
    end
    for (int i = 0; i < list_count; i++) begin
      e.rank    = RANK_W'(i);
      e.track   = list_track[i];
      e.hit     = list_hit[i];
      e.sig     = ENT_W'(list_sig[i]);
      e.total   = TOT_W'(running_total);
      e.count   = COUNT_W'(list_count);
      e.dropped = drop;
      e.last    = (i == list_count - 1);
      awaited_entries.push_back(e);
    end
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Offer one item, idling first at the current gap rate, and hold it until taken.
  task automatic offer_item(kind_t kind, logic [ID_W-1:0] trk, logic [ID_W-1:0] hit,
                            logic signed [SIG_W-1:0] sig);
    @(negedge clk);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_track_id     <= trk;
    in_hit_id       <= hit;
    in_signal_value <= sig;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rank_contribution(kind, trk, hit, sig);
    items_accepted++;
    if (kind == KIND_CLEAR) clears_accepted++;
  endtask

  // Drop valid and wait for every queued entry, then let the datapath go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: honor a requested hold-off first, otherwise stall at the current rate.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each taken entry against the oldest prediction.
  always @(posedge clk) begin : entry_checker
    ranked_entry_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_entries.size() == 0) begin
        $error("unexpected list entry: rank %0d track %0d", out_rank, out_entry_track);
        errors++;
      end else begin
        want = awaited_entries.pop_front();
        check_field("rank", want.rank, out_rank);
        check_field("entry_track", want.track, out_entry_track);
        check_field("entry_hit", want.hit, out_entry_hit);
        check_field("entry_signal", $signed(want.sig), out_entry_signal);
        check_field("total_signal", $signed(want.total), out_total_signal);
        check_field("entry_count", want.count, out_entry_count);
        check_field("dropped", want.dropped, out_dropped);
        check_field("last_entry", want.last, out_last_entry);
        entries_checked++;
        if (out_dropped && out_last_entry) drops_seen++;
      end
    end
  end

  initial begin : stimulus
    ranked_entry_t typed_want;
    logic [ID_W-1:0] trk;
    logic signed [SIG_W-1:0] sig;
    int per_phase;

    // Directed rows: extremes first, then fill, tie, drop, evict and re-sort cases.
    script[0]  = '{KIND_ADD, 31'd0, 31'd0, 32'sd0, 1'b1, 31'd0, 40'sd0, 48'sd0};
    script[1]  = '{KIND_CLEAR, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF,
                   1'b0, 31'd0, 40'sd0, 48'sd0};
    // Most negative signal clamps to one above it, -2147483647.
    script[2]  = '{KIND_ADD, 31'h7FFF_FFFF, 31'h7FFF_FFFF, SIG_MOST_NEG, 1'b1,
                   31'h7FFF_FFFF, -40'sd2147483647, -48'sd2147483647};
    script[3]  = '{KIND_CLEAR, 31'd0, 31'd0, SIG_MOST_NEG, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[4]  = '{KIND_ADD, 31'h7FFF_FFFF, 31'd0, 32'sh7FFF_FFFF, 1'b1,
                   31'd0, 40'sd2147483647, 48'sd2147483647};
    // Same track again: signal accumulates, the stored hit stays.
    script[5]  = '{KIND_ADD, 31'h7FFF_FFFF, 31'd5, 32'sh7FFF_FFFF, 1'b1,
                   31'd0, 40'sd4294967294, 48'sd4294967294};
    script[6]  = '{KIND_ADD, 31'd1, 31'd11, 32'sd100, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[7]  = '{KIND_ADD, 31'd2, 31'd12, 32'sd100, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[8]  = '{KIND_ADD, 31'd3, 31'd13, -32'sd5, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[9]  = '{KIND_ADD, 31'd4, 31'd14, 32'sh7FFF_FFFF, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[10] = '{KIND_ADD, 31'd5, 31'd15, -32'sd100, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[11] = '{KIND_ADD, 31'd6, 31'd16, 32'sd100, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[12] = '{KIND_ADD, 31'd8, 31'd18, -32'sd5, 1'b0, 31'd0, 40'sd0, 48'sd0};
    // List full: newcomer equal to the smallest is dropped, a larger one evicts it.
    script[13] = '{KIND_ADD, 31'd9, 31'd19, -32'sd100, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[14] = '{KIND_ADD, 31'd10, 31'd20, -32'sd99, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[15] = '{KIND_ADD, 31'd2, 31'd22, 32'sd1, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[16] = '{KIND_ADD, 31'd3, 31'd23, -32'sd200, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[17] = '{KIND_ADD, 31'd11, 31'd24, SIG_MOST_NEG, 1'b0, 31'd0, 40'sd0, 48'sd0};
    script[18] = '{KIND_CLEAR, 31'h2AAA_AAAA, 31'h5555_5555, 32'sh5555_5555,
                   1'b0, 31'd0, 40'sd0, 48'sd0};
    script[19] = '{KIND_ADD, 31'h5555_5555, 31'h2AAA_AAAA, 32'shAAAA_AAAA,
                   1'b0, 31'd0, 40'sd0, 48'sd0};

    // Every input known from time zero.
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_ADD;
    in_track_id     = '0;
    in_hit_id       = '0;
    in_signal_value = '0;
    gap_pct         = 0;
    stall_pct       = 0;
    hold_left       = 0;
    list_count      = 0;
    running_total   = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < SCRIPT_LEN; r++) begin
      offer_item(script[r].kind, script[r].trk, script[r].hit, script[r].sig);
      if (script[r].typed) begin
        // Swap the predicted entry for the one read straight off the row.
        void'(awaited_entries.pop_back());
        typed_want.rank    = '0;
        typed_want.track   = script[r].trk;
        typed_want.hit     = script[r].w_hit;
        typed_want.sig     = script[r].w_sig;
        typed_want.total   = script[r].w_total;
        typed_want.count   = COUNT_W'(1);
        typed_want.dropped = 1'b0;
        typed_want.last    = 1'b1;
        awaited_entries.push_back(typed_want);
      end
    end
    settle();

    // Full-scale runs: one track driven hard positive, then hard negative.
    for (int run = 0; run < 2; run++) begin
      trk = ID_W'($urandom);
      offer_item(KIND_CLEAR, ID_W'($urandom), ID_W'($urandom), SIG_W'($urandom));
      for (int n = 0; n < SAT_ADDS; n++) begin
        if (run == 0) sig = 32'sh7FFF_FFFF;
        else sig = n[0] ? SIG_MOST_NEG : SIG_NEG_LIM;
        offer_item(KIND_ADD, trk, ID_W'($urandom), sig);
        sat_adds_done++;
      end
      settle();
    end

    // Random phases: varied idling, then a long output hold with the input kept busy.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin gap_pct = 0;  stall_pct = 0;  per_phase = 45; end
        1: begin gap_pct = 66; stall_pct = 0;  per_phase = 50; end
        2: begin gap_pct = 0;  stall_pct = 66; per_phase = 50; end
        3: begin gap_pct = 17; stall_pct = 17; per_phase = 50; end
        default: begin
          gap_pct = 0; stall_pct = 0; per_phase = 45;
          hold_left = HOLD_CYCLES;
        end
      endcase
      // A fresh pool larger than the list, so repeats, evictions and drops all occur.
      for (int i = 0; i < POOL_SIZE; i++) begin
        case ($urandom_range(2))
          0: track_pool[i] = ID_W'($urandom_range(15));
          1: track_pool[i] = ID_W'($urandom);
          default: track_pool[i] = $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
        endcase
      end
      for (int k = 0; k < per_phase; k++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: sig = SIG_W'($urandom_range(40) - 20);
          4, 5:       sig = SIG_W'($urandom);
          6: begin
            case ($urandom_range(3))
              0: sig = SIG_MOST_NEG;
              1: sig = SIG_NEG_LIM;
              2: sig = 32'sh7FFF_FFFF;
              default: sig = '0;
            endcase
          end
          default:    sig = SIG_W'($urandom_range(2000000) - 1000000);
        endcase
        if ($urandom_range(99) < 15) trk = ID_W'($urandom);
        else trk = track_pool[$urandom_range(POOL_SIZE - 1)];
        if ($urandom_range(99) < 5) offer_item(KIND_CLEAR, trk, ID_W'($urandom), sig);
        else offer_item(KIND_ADD, trk, ID_W'($urandom), sig);
      end
      settle();
    end

    $display("tb: %0d items taken (%0d clears, %0d in full-scale runs), %0d entries checked",
             items_accepted, clears_accepted, sat_adds_done, entries_checked);
    $display("tb: %0d adds dropped a newcomer; idle mixes 0/66/17 pct, %0d-cycle output hold",
             drops_seen, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tca_pkg.sv
rtl/tca_sat_add.sv
rtl/tca_slot_store.sv
rtl/topk_contributor_accumulator_core.sv
rtl/tca_checker.sv
test/tb.sv
